FILE: rtl/ctl_pkg.sv
// Shared types, token kind codes and character classes for the command
// token lexer. No dependencies; ctl_step and command_token_lexer_core import this package.
`default_nettype none

package ctl_pkg;

  localparam int CTL_LEXEME_MAX = 256;

  // Token kinds
  localparam logic [3:0] K_EOL     = 4'd0;
  localparam logic [3:0] K_END     = 4'd1;
  localparam logic [3:0] K_SYM     = 4'd2;
  localparam logic [3:0] K_NUM     = 4'd3;
  localparam logic [3:0] K_STR     = 4'd4;
  localparam logic [3:0] K_PUNCT   = 4'd5;
  localparam logic [3:0] K_GT      = 4'd6;
  localparam logic [3:0] K_GTGT    = 4'd7;
  localparam logic [3:0] K_INVALID = 4'd8;

  // String termination codes
  localparam logic [1:0] SERR_NONE = 2'd0;
  localparam logic [1:0] SERR_EOL  = 2'd1;
  localparam logic [1:0] SERR_END  = 2'd2;

  // Characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] lexeme_byte;
    logic       byte_valid;
    logic       token_last;
    logic [1:0] string_error;
  } res_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
  endfunction

  function automatic logic is_sym_ch(logic [7:0] c);
    return c == "_" || c == "$" || c == "/" || c == "*" || c == "?";
  endfunction

  function automatic logic is_symh_ch(logic [7:0] c);
    return is_sym_ch(c) || c == CH_HASH;
  endfunction

  function automatic logic is_msym_ch(logic [7:0] c);
    return is_sym_ch(c) || c == CH_MINUS;
  endfunction

  function automatic logic is_num_ch(logic [7:0] c);
    return c == "+" || c == CH_MINUS || c == CH_DOT || c == "e" || c == "E";
  endfunction

  function automatic logic is_punct_ch(logic [7:0] c);
    return c == "|" || c == CH_DOT || c == "(" || c == ")" || c == "[" || c == "]" ||
           c == "{" || c == "}" || c == ":" || c == "," || c == "=";
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ctl_in_if.sv
// Input channel of the command token lexer: one byte or end mark per item.
// Standalone; valid/ready handshake.
`default_nettype none

interface ctl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  logic       skip_newlines;

  modport source (output valid, output in_byte, output end_of_input,
                  output skip_newlines, input ready);
  modport sink   (input valid, input in_byte, input end_of_input,
                  input skip_newlines, output ready);
endinterface

`default_nettype wire

FILE: rtl/ctl_out_if.sv
// Result channel of the command token lexer: one lexeme byte or token mark
// per item. Standalone; valid/ready handshake.
`default_nettype none

interface ctl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] lexeme_byte;
  logic       byte_valid;
  logic       token_last;
  logic [1:0] string_error;

  modport source (output valid, output token_kind, output lexeme_byte,
                  output byte_valid, output token_last, output string_error,
                  input ready);
  modport sink   (input valid, input token_kind, input lexeme_byte,
                  input byte_valid, input token_last, input string_error,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/ctl_step.sv
// Lexer state register and the per-item step logic: one byte in, up to
// three results out. Depends on ctl_pkg.
`default_nettype none

module ctl_step import ctl_pkg::*; #(
  parameter int LEXEME_MAX = CTL_LEXEME_MAX
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic           hash_in_symbols,
  input  logic [7:0]     c_in,
  input  logic           eoi,
  input  logic           skip,
  output logic [1:0]     res_n,
  output res_t [2:0]     res
);

  localparam int LW = $clog2(LEXEME_MAX);
  localparam logic [LW-1:0] LenCap = LW'(LEXEME_MAX - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_COMMENT, PH_SYM, PH_SYMH, PH_MINUS, PH_MSYM,
    PH_NUM, PH_GT, PH_STR, PH_ESC, PH_OCT
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [7:0]      quote;
    logic [8:0]      oct;
    logic [1:0]      octn;
    logic [LW-1:0]   len;
    logic            bs;
    logic [3:0]      kind;
  } lex_t;

  typedef struct packed {
    lex_t            st;
    logic [1:0]      n;
    res_t [2:0]      res;
  } work_t;

  lex_t  state_r;
  lex_t  state_nxt;
  work_t wk;

  function automatic work_t f_emit(work_t w, logic [3:0] kind, logic [7:0] b, logic v,
                                   logic last, logic [1:0] err);
    work_t o;
    o = w;
    // results past the third are dropped
    if (w.n != 2'd3) begin
      o.res[w.n] = '{token_kind: kind, lexeme_byte: v ? b : 8'd0, byte_valid: v,
                     token_last: last, string_error: err};
      o.n = w.n + 2'd1;
    end
    return o;
  endfunction

  function automatic work_t f_add(work_t w, logic [7:0] c);
    work_t o;
    o = w;
    if (w.st.len < LenCap) begin
      o = f_emit(w, w.st.kind, c, 1'b1, 1'b0, SERR_NONE);
      o.st.len = w.st.len + LW'(1);
    end
    return o;
  endfunction

  function automatic work_t f_close(work_t w, logic [1:0] err);
    work_t o;
    o = f_emit(w, w.st.kind, 8'd0, 1'b0, 1'b1, err);
    o.st.phase = PH_IDLE;
    return o;
  endfunction

  function automatic work_t f_begin(work_t w, logic [3:0] kind, phase_t ph);
    work_t o;
    o = w;
    o.st.kind  = kind;
    o.st.phase = ph;
    o.st.len   = '0;
    return o;
  endfunction

  function automatic work_t f_start(work_t w, logic [7:0] c, logic sk, logic hs);
    work_t o;
    o = w;
    if (is_space(c)) begin
      if (c == CH_LF && !sk) o = f_emit(o, K_EOL, CH_LF, 1'b1, 1'b1, SERR_NONE);
    end else if (c == CH_HASH && !hs) begin
      o.st.phase = PH_COMMENT;
    end else if (c == CH_GT) begin
      o = f_begin(o, K_GT, PH_GT);
    end else if (is_punct_ch(c)) begin
      o = f_emit(o, K_PUNCT, c, 1'b1, 1'b1, SERR_NONE);
    end else if (c == CH_HASH) begin
      o = f_add(f_begin(o, K_SYM, PH_SYMH), c);
    end else if (is_alpha(c) || is_sym_ch(c)) begin
      o = f_add(f_begin(o, K_SYM, PH_SYM), c);
    end else if (c == CH_MINUS) begin
      o = f_begin(o, K_SYM, PH_MINUS);
    end else if (is_digit(c)) begin
      o = f_add(f_begin(o, K_NUM, PH_NUM), c);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      o = f_begin(o, K_STR, PH_STR);
      o.st.quote = c;
    end else begin
      o = f_emit(o, K_INVALID, c, 1'b1, 1'b1, SERR_NONE);
    end
    return o;
  endfunction

  // A byte that ends a token is handled again in the following phase;
  // at most three passes are ever needed (octal, string, token start).
  function automatic work_t f_process(work_t w, logic [7:0] c, logic sk, logic hs);
    work_t      o;
    logic       again;
    logic [1:0] octn_inc;
    o = w;
    again = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (again) begin
        again = 1'b0;
        unique case (o.st.phase)
          PH_COMMENT: begin
            if (c == CH_LF) begin
              o.st.phase = PH_IDLE;
              again = 1'b1;
            end
          end
          PH_SYM, PH_SYMH: begin
            if (is_alpha(c) || is_digit(c) ||
                (o.st.phase == PH_SYMH ? is_symh_ch(c) : is_sym_ch(c))) begin
              o = f_add(o, c);
            end else begin
              o = f_close(o, SERR_NONE);
              again = 1'b1;
            end
          end
          PH_MSYM: begin
            if (is_alpha(c) || is_digit(c) || is_msym_ch(c)) begin
              o = f_add(o, c);
            end else begin
              o = f_close(o, SERR_NONE);
              again = 1'b1;
            end
          end
          PH_NUM: begin
            if (is_digit(c) || is_num_ch(c)) begin
              o = f_add(o, c);
            end else begin
              o = f_close(o, SERR_NONE);
              again = 1'b1;
            end
          end
          PH_MINUS: begin
            if (c == CH_DOT || is_digit(c)) begin
              o.st.kind  = K_NUM;
              o.st.phase = PH_NUM;
              o = f_add(f_add(o, CH_MINUS), c);
            end else if (is_alpha(c) || is_msym_ch(c)) begin
              o.st.phase = PH_MSYM;
              o = f_add(f_add(o, CH_MINUS), c);
            end else begin
              o = f_emit(o, K_SYM, CH_MINUS, 1'b1, 1'b1, SERR_NONE);
              o.st.phase = PH_IDLE;
              again = 1'b1;
            end
          end
          PH_GT: begin
            if (c == CH_GT) begin
              o = f_emit(o, K_GTGT, CH_GT, 1'b1, 1'b0, SERR_NONE);
              o = f_emit(o, K_GTGT, CH_GT, 1'b1, 1'b1, SERR_NONE);
              o.st.phase = PH_IDLE;
            end else begin
              o = f_emit(o, K_GT, CH_GT, 1'b1, 1'b1, SERR_NONE);
              o.st.phase = PH_IDLE;
              again = 1'b1;
            end
          end
          PH_STR: begin
            if (c == o.st.quote) begin
              o = f_close(o, SERR_NONE);
            end else if (c == CH_LF) begin
              o = f_close(o, SERR_EOL);
              again = 1'b1;
            end else if (c == CH_BSL) begin
              o.st.phase = PH_ESC;
            end else begin
              o = f_add(o, c);
            end
          end
          PH_ESC: begin
            o.st.phase = PH_STR;
            if (c == CH_LC_B)      o = f_add(o, CH_BS);
            else if (c == CH_LC_N) o = f_add(o, CH_LF);
            else if (c == CH_LC_R) o = f_add(o, CH_CR);
            else if (c == CH_LC_T) o = f_add(o, CH_HT);
            else if (is_octal(c)) begin
              o.st.oct   = {6'd0, c[2:0]};
              o.st.octn  = 2'd1;
              o.st.phase = PH_OCT;
            end else begin
              o = f_add(o, c);
            end
          end
          PH_OCT: begin
            if (is_octal(c)) begin
              octn_inc  = o.st.octn + 2'd1;
              o.st.oct  = {o.st.oct[5:0], c[2:0]};
              o.st.octn = octn_inc;
              if (octn_inc == 2'd3) begin
                o = f_add(o, o.st.oct[7:0]);
                o.st.oct   = '0;
                o.st.octn  = '0;
                o.st.phase = PH_STR;
              end
            end else begin
              o = f_add(o, o.st.oct[7:0]);
              o.st.oct   = '0;
              o.st.octn  = '0;
              o.st.phase = PH_STR;
              again = 1'b1;
            end
          end
          default: begin
            o.st.phase = PH_IDLE;
            o = f_start(o, c, sk, hs);
          end
        endcase
      end
    end
    return o;
  endfunction

  // Close any open token, then report end of input.
  function automatic work_t f_end(work_t w);
    work_t o;
    o = w;
    unique case (o.st.phase)
      PH_SYM, PH_SYMH, PH_MSYM, PH_NUM: o = f_close(o, SERR_NONE);
      PH_MINUS: o = f_emit(o, K_SYM, CH_MINUS, 1'b1, 1'b1, SERR_NONE);
      PH_GT:    o = f_emit(o, K_GT, CH_GT, 1'b1, 1'b1, SERR_NONE);
      PH_STR:   o = f_close(o, SERR_END);
      PH_ESC:   o = f_close(f_add(o, CH_BSL), SERR_END);
      PH_OCT: begin
        o = f_add(o, o.st.oct[7:0]);
        o.st.oct  = '0;
        o.st.octn = '0;
        o = f_close(o, SERR_END);
      end
      default: ;
    endcase
    o.st.phase = PH_IDLE;
    o = f_emit(o, K_END, 8'd0, 1'b0, 1'b1, SERR_NONE);
    return o;
  endfunction

  always_comb begin
    wk.st  = state_r;
    wk.n   = 2'd0;
    wk.res = '0;
    if (eoi) begin
      if (state_r.bs) begin
        wk.st.bs = 1'b0;
        wk = f_process(wk, CH_BSL, skip, hash_in_symbols);
      end
      wk = f_end(wk);
    end else if (state_r.bs) begin
      // drop backslash-newline; otherwise release the held backslash
      wk.st.bs = 1'b0;
      if (c_in != CH_LF) begin
        wk = f_process(wk, CH_BSL, skip, hash_in_symbols);
        if (c_in == CH_BSL) wk.st.bs = 1'b1;
        else wk = f_process(wk, c_in, skip, hash_in_symbols);
      end
    end else if (c_in == CH_BSL) begin
      wk.st.bs = 1'b1;
    end else begin
      wk = f_process(wk, c_in, skip, hash_in_symbols);
    end
  end

  assign state_nxt = wk.st;
  assign res_n     = wk.n;
  assign res       = wk.res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, default: '0};
    end else if (go) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/command_token_lexer_core.sv
// Command token lexer top level: input register, step logic, result buffer.
// Depends on ctl_pkg, ctl_in_if, ctl_out_if and ctl_step.
//
// Usage:
//   in_ch  carries one input item per handshake: a byte, or an end mark with
//          end_of_input=1, plus the skip_newlines flag for that byte.
//   out_ch carries one result item per handshake: a lexeme byte and/or a
//          token-end mark with the token kind and, on a string's end, its
//          termination code.
//   cfg_we/cfg_wdata write hash_in_symbols; write only while the block is idle.
//   Results: an accepted item is held in the input register until the step
//   logic takes it; its results are then written to the result buffer.
//   Throughput: one input item per cycle while out_ch is ready and each
//   item gives at most one result; an item giving k results (k up to 3)
//   holds the result buffer for k output handshakes. Items that give no
//   result pass even while the buffer is busy. The bound is the single
//   3-entry result buffer. Reset (rst_n low, synchronous) empties both
//   stages, puts the lexer between tokens and clears hash_in_symbols.
//   When out_ch stalls, the current result holds and the input register
//   fills, then in_ch.ready drops.
`default_nettype none

module command_token_lexer_core import ctl_pkg::*; #(
  parameter int LEXEME_MAX = CTL_LEXEME_MAX
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  ctl_in_if.sink       in_ch,
  ctl_out_if.source    out_ch
);

  logic       hash_r;
  logic       inq_valid_r;
  logic [7:0] inq_byte_r;
  logic       inq_eoi_r;
  logic       inq_skip_r;

  res_t [2:0] buf_r;
  logic [1:0] buf_cnt_r;
  logic [1:0] buf_idx_r;

  logic [1:0] step_n;
  res_t [2:0] step_res;
  logic       buf_free;
  logic       go;
  logic       in_take;
  logic       out_take;
  res_t       out_res;

  ctl_step #(.LEXEME_MAX(LEXEME_MAX)) u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (go),
    .hash_in_symbols (hash_r),
    .c_in            (inq_byte_r),
    .eoi             (inq_eoi_r),
    .skip            (inq_skip_r),
    .res_n           (step_n),
    .res             (step_res)
  );

  assign out_take = out_ch.valid && out_ch.ready;
  assign buf_free = (buf_cnt_r == 2'd0) || (buf_cnt_r == 2'd1 && out_ch.ready);
  assign go       = inq_valid_r && (step_n == 2'd0 || buf_free);
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !inq_valid_r || go;

  assign out_res             = buf_r[buf_idx_r];
  assign out_ch.valid        = buf_cnt_r != 2'd0;
  assign out_ch.token_kind   = out_res.token_kind;
  assign out_ch.lexeme_byte  = out_res.lexeme_byte;
  assign out_ch.byte_valid   = out_res.byte_valid;
  assign out_ch.token_last   = out_res.token_last;
  assign out_ch.string_error = out_res.string_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= 1'b0;
      inq_valid_r <= 1'b0;
      buf_cnt_r   <= 2'd0;
      buf_idx_r   <= 2'd0;
    end else begin
      if (cfg_we) hash_r <= cfg_wdata;
      if (in_take) inq_valid_r <= 1'b1;
      else if (go) inq_valid_r <= 1'b0;
      if (go && step_n != 2'd0) begin
        buf_cnt_r <= step_n;
        buf_idx_r <= 2'd0;
      end else if (out_take) begin
        buf_cnt_r <= buf_cnt_r - 2'd1;
        buf_idx_r <= buf_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_byte_r <= in_ch.in_byte;
      inq_eoi_r  <= in_ch.end_of_input;
      inq_skip_r <= in_ch.skip_newlines;
    end
    if (go && step_n != 2'd0) buf_r <= step_res;
  end

`ifndef ASSERT_OFF
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, buf_idx_r} + {1'b0, buf_cnt_r}) <= 3'd3)
    else $error("result buffer index and count exceed its depth");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_cnt_r != 2'd0 && !out_ch.ready) |=>
      (buf_cnt_r == $past(buf_cnt_r) && buf_idx_r == $past(buf_idx_r)))
    else $error("result buffer moved while output stalled");

  a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.token_kind == K_END) |->
      (out_ch.token_last && !out_ch.byte_valid))
    else $error("end token without last mark or with a byte");
`endif

endmodule

`default_nettype wire
